>>> src/grid_rectangle_occupancy_allocator_defines.svh
// Assertion macros for the occupancy allocator.
// Both expect clk in scope; GROA_ASSERT also expects rst.
`ifndef GRID_RECTANGLE_OCCUPANCY_ALLOCATOR_DEFINES_SVH
`define GRID_RECTANGLE_OCCUPANCY_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define GROA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GROA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GROA_ASSERT(lbl, prop, msg)
`define GROA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> src/groa_pkg.sv
`timescale 1ns / 1ps
package groa_pkg;

  localparam int MAX_COLS      = 64;
  localparam int MAX_ROWS      = 64;
  localparam int MAX_FOOTPRINT = 16;
  localparam int OWNER_BITS    = 8;

  localparam int COL_BITS    = $clog2(MAX_COLS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
  localparam int FOOT_BITS   = $clog2(MAX_FOOTPRINT);
  localparam int SIZE_BITS   = 5;
  localparam int ORIGIN_BITS = 8;
  localparam int GRID_BITS   = 7;
  localparam int FUNC_BITS   = 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_CHECK  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_PLACE  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 2'd1;

  typedef struct packed {
    logic                 in_grid;
    logic [COL_BITS-1:0]  ox;
    logic [ROW_BITS-1:0]  oy;
    logic [FOOT_BITS-1:0] sx_m1;
    logic [FOOT_BITS-1:0] sy_m1;
  } geom_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [OWNER_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } res_t;

endpackage

>>> src/groa_mem.sv
`timescale 1ns / 1ps
module groa_mem (
  input  logic                           clk,
  input  groa_pkg::mem_req_t             req,
  output logic [groa_pkg::OWNER_BITS-1:0] rdata
);
  import groa_pkg::*;

  logic [OWNER_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

>>> src/groa_geom.sv
`timescale 1ns / 1ps
module groa_geom (
  input  logic [groa_pkg::ORIGIN_BITS-1:0] origin_x,
  input  logic [groa_pkg::ORIGIN_BITS-1:0] origin_y,
  input  logic [groa_pkg::SIZE_BITS-1:0]   size_x,
  input  logic [groa_pkg::SIZE_BITS-1:0]   size_y,
  input  logic [groa_pkg::GRID_BITS-1:0]   grid_cols,
  input  logic [groa_pkg::GRID_BITS-1:0]   grid_rows,
  output groa_pkg::geom_t                  geom
);
  import groa_pkg::*;

  logic [SIZE_BITS-1:0]   sx_c;
  logic [SIZE_BITS-1:0]   sy_c;
  logic [GRID_BITS-1:0]   cols_eff;
  logic [GRID_BITS-1:0]   rows_eff;
  logic [ORIGIN_BITS-1:0] x_end;
  logic [ORIGIN_BITS-1:0] y_end;

  always_comb begin
    if (size_x == '0) begin
      sx_c = SIZE_BITS'(1);
    end else if (size_x > SIZE_BITS'(MAX_FOOTPRINT)) begin
      sx_c = SIZE_BITS'(MAX_FOOTPRINT);
    end else begin
      sx_c = size_x;
    end
    if (size_y == '0) begin
      sy_c = SIZE_BITS'(1);
    end else if (size_y > SIZE_BITS'(MAX_FOOTPRINT)) begin
      sy_c = SIZE_BITS'(MAX_FOOTPRINT);
    end else begin
      sy_c = size_y;
    end
    cols_eff = (grid_cols > GRID_BITS'(MAX_COLS)) ? GRID_BITS'(MAX_COLS) : grid_cols;
    rows_eff = (grid_rows > GRID_BITS'(MAX_ROWS)) ? GRID_BITS'(MAX_ROWS) : grid_rows;
    // origin is non-negative here, so the end column fits without a sign
    x_end = {1'b0, origin_x[ORIGIN_BITS-2:0]} + ORIGIN_BITS'(sx_c);
    y_end = {1'b0, origin_y[ORIGIN_BITS-2:0]} + ORIGIN_BITS'(sy_c);
    geom.in_grid = !origin_x[ORIGIN_BITS-1] && !origin_y[ORIGIN_BITS-1] &&
                   (x_end <= ORIGIN_BITS'(cols_eff)) && (y_end <= ORIGIN_BITS'(rows_eff));
    geom.ox    = origin_x[COL_BITS-1:0];
    geom.oy    = origin_y[ROW_BITS-1:0];
    geom.sx_m1 = FOOT_BITS'(sx_c - SIZE_BITS'(1));
    geom.sy_m1 = FOOT_BITS'(sy_c - SIZE_BITS'(1));
  end

endmodule

>>> src/groa_ctrl.sv
`timescale 1ns / 1ps
module groa_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic [groa_pkg::FUNC_BITS-1:0]   req_func,
  input  logic [groa_pkg::OWNER_BITS-1:0]  req_owner,
  input  groa_pkg::geom_t                  req_geom,
  output groa_pkg::mem_req_t               mem_req,
  input  logic [groa_pkg::OWNER_BITS-1:0]  mem_rdata,
  output groa_pkg::res_t                   res,
  input  logic                             res_ready
);
  import groa_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_REMOVE = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_PLACE  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]            st;
  logic [ADDR_BITS-1:0]  cnt;
  logic                  issue_done;
  logic                  rd_v;
  logic                  rd_last;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  fail;
  logic [FOOT_BITS-1:0]  dx;
  logic [FOOT_BITS-1:0]  dy;
  logic [FUNC_BITS-1:0]  func;
  logic [OWNER_BITS-1:0] owner;
  geom_t                 g;
  logic                  ok_r;

  logic [COL_BITS-1:0]  cell_x;
  logic [ROW_BITS-1:0]  cell_y;
  logic [ADDR_BITS-1:0] cell_addr;
  logic                 last_cell;
  logic                 pass;

  assign cell_x    = g.ox + COL_BITS'(dx);
  assign cell_y    = g.oy + ROW_BITS'(dy);
  assign cell_addr = {cell_y, cell_x};
  assign last_cell = (dx == g.sx_m1) && (dy == g.sy_m1);
  assign pass      = !fail && (mem_rdata == '0);

  assign req_ready = (st == ST_IDLE);
  assign res.valid = (st == ST_DONE);
  assign res.ok    = ok_r;

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt;
    mem_req.wdata = '0;
    mem_req.raddr = cnt;
    case (st)
      ST_INIT, ST_CLEAR: begin
        mem_req.we = 1'b1;
      end
      ST_REMOVE: begin
        mem_req.we    = rd_v && (mem_rdata == owner);
        mem_req.waddr = rd_addr;
      end
      ST_CHECK: begin
        mem_req.raddr = cell_addr;
      end
      ST_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cell_addr;
        mem_req.wdata = owner;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_INIT;
      cnt        <= '0;
      issue_done <= 1'b0;
      rd_v       <= 1'b0;
      rd_last    <= 1'b0;
      fail       <= 1'b0;
      dx         <= '0;
      dy         <= '0;
      ok_r       <= 1'b0;
    end else begin
      case (st)
        ST_INIT, ST_CLEAR: begin
          cnt <= cnt + ADDR_BITS'(1);
          if (&cnt) begin
            ok_r <= 1'b1;
            st   <= (st == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            func       <= req_func;
            owner      <= req_owner;
            g          <= req_geom;
            cnt        <= '0;
            dx         <= '0;
            dy         <= '0;
            issue_done <= 1'b0;
            rd_v       <= 1'b0;
            rd_last    <= 1'b0;
            fail       <= 1'b0;
            if (req_func == FUNC_CLEAR) begin
              st <= ST_CLEAR;
            end else if (req_owner == '0) begin
              ok_r <= 1'b0;
              st   <= ST_DONE;
            end else if (req_func == FUNC_REMOVE) begin
              st <= ST_REMOVE;
            end else if (!req_geom.in_grid) begin
              ok_r <= 1'b0;
              st   <= ST_DONE;
            end else begin
              st <= ST_CHECK;
            end
          end
        end
        ST_REMOVE: begin
          // read one entry ahead of the write-back
          rd_v    <= !issue_done;
          rd_addr <= cnt;
          if (!issue_done) begin
            cnt <= cnt + ADDR_BITS'(1);
            if (&cnt) begin
              issue_done <= 1'b1;
            end
          end
          if (rd_v && (&rd_addr)) begin
            ok_r <= 1'b1;
            st   <= ST_DONE;
          end
        end
        ST_CHECK: begin
          rd_v    <= !issue_done;
          rd_last <= last_cell && !issue_done;
          if (!issue_done) begin
            if (dx == g.sx_m1) begin
              dx <= '0;
              dy <= dy + FOOT_BITS'(1);
            end else begin
              dx <= dx + FOOT_BITS'(1);
            end
            if (last_cell) begin
              issue_done <= 1'b1;
            end
          end
          if (rd_v && (mem_rdata != '0)) begin
            fail <= 1'b1;
          end
          if (rd_v && rd_last) begin
            if (pass && (func == FUNC_PLACE)) begin
              dx <= '0;
              dy <= '0;
              st <= ST_PLACE;
            end else begin
              ok_r <= pass;
              st   <= ST_DONE;
            end
          end
        end
        ST_PLACE: begin
          if (dx == g.sx_m1) begin
            dx <= '0;
            dy <= dy + FOOT_BITS'(1);
          end else begin
            dx <= dx + FOOT_BITS'(1);
          end
          if (last_cell) begin
            ok_r <= 1'b1;
            st   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/grid_rectangle_occupancy_allocator.sv
`timescale 1ns / 1ps
// Occupancy map of 64 x 64 cells with an 8-bit owner tag per cell (0 = free).
// Requests arrive on the s_ stream: tuser carries the function (check, place,
// remove owner, clear all), tdata the owner tag, origin and size. Each request
// gives exactly one result on the m_ stream: tdata bit 0 is the ok flag.
// Grid columns and rows are set on the cfg_ write channel (index 0 columns,
// index 1 rows); the channel is always ready.
// The map sits in one 4096 x 8 memory with a single read and a single write
// port, so the work from acceptance to the result follows the memory port:
//   check:  one cell read per cycle over the sx*sy cells, then the last read data is checked
//   place:  check, then a write of each of the sx*sy cells
//   remove: scan of every entry, read ahead of the write-back
//   clear:  write of every entry; a rectangle outside the grid or owner 0: no memory access
// One request is worked on at a time; s_tready is high only when idle, at the
// earliest in the cycle its result appears.
// After reset a clearing pass zeroes the map; s_tready stays low through it,
// configuration writes are still taken.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and worked, and its result waits until the
// register frees.
module grid_rectangle_occupancy_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // owner_id[7:0], origin_x[15:8], origin_y[23:16],
                                 // size_x[28:24], size_y[33:29], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // ok[0], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [groa_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [groa_pkg::GRID_BITS-1:0]    cfg_data
);
  import groa_pkg::*;
`include "grid_rectangle_occupancy_allocator_defines.svh"

  logic [GRID_BITS-1:0]  grid_cols;
  logic [GRID_BITS-1:0]  grid_rows;
  geom_t                 geom;
  mem_req_t              mem_req;
  logic [OWNER_BITS-1:0] mem_rdata;
  res_t                  res;
  logic                  res_ready;
  logic                  m_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= GRID_BITS'(MAX_COLS);
      grid_rows <= GRID_BITS'(MAX_ROWS);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_COLS: grid_cols <= cfg_data;
        CFG_GRID_ROWS: grid_rows <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  groa_geom u_geom (
    .origin_x  (s_tdata[15:8]),
    .origin_y  (s_tdata[23:16]),
    .size_x    (s_tdata[28:24]),
    .size_y    (s_tdata[33:29]),
    .grid_cols (grid_cols),
    .grid_rows (grid_rows),
    .geom      (geom)
  );

  groa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_func  (s_tuser),
    .req_owner (s_tdata[7:0]),
    .req_geom  (geom),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  groa_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_ok <= res.ok;
    end
  end

  assign m_tdata = {7'b0, m_ok};

  `GROA_ASSERT_RST(a_init_after_rst, rst |=> !s_tready, "request taken during clearing pass")
  `GROA_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "second request taken")
  `GROA_ASSERT(a_no_write_idle, mem_req.we |-> !s_tready, "map written while idle")
  `GROA_ASSERT(a_res_not_idle, res.valid |-> !s_tready, "result pending while idle")

endmodule
